// ----- rtl/sts_pkg.sv -----
// Shared types and codes for the sorted table block.
// No dependencies; compile first.
package sts_pkg;

  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int CAP_W    = 5;

  // action codes; any other code acts as a find
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUP       = 2'd3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_REM
  } cell_op_t;

  typedef struct packed {
    logic valid;
    logic lt;
    logic eq;
  } cell_stat_t;

endpackage

// ----- rtl/sts_if.sv -----
// Valid/ready channel interfaces for request, response and configuration beats.
// Depends on sts_pkg.
interface sts_req_if #(parameter int KEY_WIDTH = 32);
  import sts_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [ACTION_W-1:0]         action;
  logic signed [KEY_WIDTH-1:0] key;
  modport source (output valid, action, key, input ready);
  modport sink (input valid, action, key, output ready);
endinterface

interface sts_rsp_if #(parameter int KEY_WIDTH = 32);
  import sts_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic [POS_W-1:0]            position;
  logic [POS_W-1:0]            count;
  logic signed [KEY_WIDTH-1:0] min_key;
  logic signed [KEY_WIDTH-1:0] max_key;
  modport source (output valid, status, position, count, min_key, max_key, input ready);
  modport sink (input valid, status, position, count, min_key, max_key, output ready);
endinterface

interface sts_cfg_if;
  import sts_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/sts_cell.sv -----
// One table cell: holds a key and its valid flag, compares against the search key,
// and shifts with its neighbors on insert and remove. Depends on sts_pkg.
module sts_cell #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sts_pkg::cell_op_t           op,
  input  logic signed [KEY_WIDTH-1:0] key_in,
  input  sts_pkg::cell_stat_t         left_stat,
  input  logic signed [KEY_WIDTH-1:0] left_key,
  input  sts_pkg::cell_stat_t         right_stat,
  input  logic signed [KEY_WIDTH-1:0] right_key,
  output sts_pkg::cell_stat_t         stat,
  output logic signed [KEY_WIDTH-1:0] key,
  output logic                        boundary
);
  import sts_pkg::*;

  assign boundary = !stat.lt && left_stat.lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      case (op)
        CELL_CMP: begin
          stat.lt <= stat.valid && (key < key_in);
          stat.eq <= stat.valid && (key == key_in);
        end
        CELL_INS: begin
          if (!stat.lt) begin
            stat.valid <= boundary ? 1'b1 : left_stat.valid;
          end
        end
        CELL_REM: begin
          if (!stat.lt) begin
            stat.valid <= right_stat.valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      CELL_INS: begin
        if (!stat.lt) begin
          key <= boundary ? key_in : left_key;
        end
      end
      CELL_REM: begin
        if (!stat.lt) begin
          key <= right_key;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/sorted_table_insert_remove_find_top.sv -----
// Sorted table of distinct signed keys: a row of compare-and-shift cells plus control.
// A request beat is taken only in idle; then the compare, apply and load steps run through
// the cell row, and the response is registered in the load step, which waits while an earlier
// response is still untaken. No new request is taken until the response is loaded.
// Reset: synchronous; table empty, capacity 16, no response pending.
// Depends on sts_pkg, sts_if and sts_cell.
module sorted_table_insert_remove_find_top #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32
) (
  input logic   clk,
  input logic   rst,
  sts_req_if.sink   req,
  sts_rsp_if.source rsp,
  sts_cfg_if.sink   cfg
);
  import sts_pkg::*;

  localparam int IDX_W = $clog2(DEPTH + 1);
  localparam int LIM_W = IDX_W > CAP_W ? IDX_W : CAP_W;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY, S_FIN} state_t;

  state_t                      state;
  logic [ACTION_W-1:0]         action;
  logic signed [KEY_WIDTH-1:0] key;
  logic [CAP_W-1:0]            capacity;
  logic [IDX_W-1:0]            used;
  logic [STATUS_W-1:0]         status;
  logic [IDX_W-1:0]            position;

  cell_op_t                    op;
  cell_stat_t                  stat [DEPTH];
  logic signed [KEY_WIDTH-1:0] ckey [DEPTH];
  logic [DEPTH-1:0]            boundary;
  logic [DEPTH-1:0]            valid_vec;
  logic [DEPTH-1:0]            eq_vec;
  logic [DEPTH-1:0]            last_vec;
  logic [IDX_W-1:0]            pos_enc;
  logic                        hit;
  logic [LIM_W-1:0]            limit;
  logic                        full;
  logic                        do_ins;
  logic                        do_rem;
  logic [STATUS_W-1:0]         status_next;
  logic signed [KEY_WIDTH-1:0] min_next;
  logic signed [KEY_WIDTH-1:0] max_next;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_stat_t                  lstat;
    cell_stat_t                  rstat;
    logic signed [KEY_WIDTH-1:0] lkey;
    logic signed [KEY_WIDTH-1:0] rkey;
    if (i == 0) begin : g_first
      assign lstat = '{valid: 1'b1, lt: 1'b1, eq: 1'b0};
      assign lkey  = '0;
    end else begin : g_mid
      assign lstat = stat[i-1];
      assign lkey  = ckey[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rstat = '0;
      assign rkey  = '0;
    end else begin : g_inner
      assign rstat = stat[i+1];
      assign rkey  = ckey[i+1];
    end
    sts_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .key_in     (key),
      .left_stat  (lstat),
      .left_key   (lkey),
      .right_stat (rstat),
      .right_key  (rkey),
      .stat       (stat[i]),
      .key        (ckey[i]),
      .boundary   (boundary[i])
    );
    assign valid_vec[i] = stat[i].valid;
    assign eq_vec[i]    = stat[i].eq;
  end

  assign last_vec = valid_vec & ~{1'b0, valid_vec[DEPTH-1:1]};
  assign hit      = |eq_vec;

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (boundary[i]) begin
        pos_enc = pos_enc | IDX_W'(i);
      end
    end
    if (stat[DEPTH-1].lt) begin
      pos_enc = pos_enc | IDX_W'(DEPTH);
    end
  end

  always_comb begin
    max_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (last_vec[i]) begin
        max_next = max_next | ckey[i];
      end
    end
    min_next = valid_vec[0] ? ckey[0] : '0;
  end

  assign limit = (LIM_W'(capacity) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(capacity);
  assign full  = LIM_W'(used) >= limit;

  always_comb begin
    do_ins = 1'b0;
    do_rem = 1'b0;
    case (action)
      ACT_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (hit) begin
          status_next = ST_DUP;
        end else begin
          status_next = ST_DONE;
          do_ins      = 1'b1;
        end
      end
      ACT_REMOVE: begin
        status_next = hit ? ST_DONE : ST_NOT_FOUND;
        do_rem      = hit;
      end
      default: begin
        status_next = hit ? ST_DONE : ST_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_CMP:   op = CELL_CMP;
      S_APPLY: op = do_ins ? CELL_INS : (do_rem ? CELL_REM : CELL_HOLD);
      default: op = CELL_HOLD;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      capacity  <= CAP_RESET;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.data;
      end
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            action <= req.action;
            key    <= req.key;
            state  <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          status   <= status_next;
          position <= pos_enc;
          if (do_ins) begin
            used <= used + 1'b1;
          end else if (do_rem) begin
            used <= used - 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid    <= 1'b1;
            rsp.status   <= status;
            rsp.position <= POS_W'(position);
            rsp.count    <= POS_W'(used);
            rsp.min_key  <= min_next;
            rsp.max_key  <= max_next;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while an operation is in progress");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    LIM_W'(used) <= LIM_W'(DEPTH))
    else $error("key count above table depth");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(used))
    else $error("cell valid flags disagree with key count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY && do_ins |=> used == $past(used) + 1'b1)
    else $error("insert did not advance the key count");

endmodule

// ----- verif/sts_table_check_pkg.sv -----
// Scoreboard for the sorted table: its own copy of keys, count and capacity,
// plus a queue of awaited response beats checked field by field.
// Depends on sts_pkg.
package sts_table_check_pkg;
  import sts_pkg::*;

  localparam int TBL_DEPTH = 16;
  localparam int KEY_W     = 32;

  localparam logic [ACTION_W-1:0] ACT_FIND  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    count;
    key_t                min_key;
    key_t                max_key;
  } table_result_t;

  class TableScoreboard;
    key_t            keys_held [TBL_DEPTH];
    int unsigned     held;
    logic [CAP_W-1:0] capacity;
    table_result_t   awaited [$];
    int              errors;
    int              beats_seen;

    function new();
      foreach (keys_held[i]) keys_held[i] = '0;
      held = 0;
      capacity = CAP_RESET;
      errors = 0;
      beats_seen = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      capacity = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(logic [ACTION_W-1:0] act, key_t k);
      int unsigned spot;
      int unsigned limit;
      bit hit;
      logic [STATUS_W-1:0] st;
      table_result_t r;
      limit = (capacity > TBL_DEPTH) ? TBL_DEPTH : capacity;
      spot = held;
      hit = 1'b0;
      for (int unsigned i = 0; i < held; i++) begin
        if (keys_held[i] >= k) begin
          spot = i;
          hit = (keys_held[i] == k);
          break;
        end
      end
      case (act)
        ACT_INSERT: begin
          if (held >= limit) begin
            st = ST_FULL;
          end else if (hit) begin
            st = ST_DUP;
          end else begin
            for (int unsigned i = held; i > spot; i--) keys_held[i] = keys_held[i-1];
            keys_held[spot] = k;
            held++;
            st = ST_DONE;
          end
        end
        ACT_REMOVE: begin
          if (!hit) begin
            st = ST_NOT_FOUND;
          end else begin
            for (int unsigned i = spot; i + 1 < held; i++) keys_held[i] = keys_held[i+1];
            held--;
            st = ST_DONE;
          end
        end
        default: begin
          st = hit ? ST_DONE : ST_NOT_FOUND;
        end
      endcase
      r.status = st;
      r.position = POS_W'(spot);
      r.count = POS_W'(held);
      r.min_key = (held == 0) ? key_t'(0) : keys_held[0];
      r.max_key = (held == 0) ? key_t'(0) : keys_held[held-1];
      awaited = {awaited, r};
    endfunction

    task report_mismatch(string field, longint got, longint want);
      if (errors < 100)
        $display("mismatch on beat %0d: %s got %0d, want %0d", beats_seen, field, got, want);
      errors++;
    endtask

    task check_result(table_result_t got);
      table_result_t want;
      beats_seen++;
      if (awaited.size() == 0) begin
        report_mismatch("unrequested beat, status", got.status, -1);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.position !== want.position)
        report_mismatch("position", got.position, want.position);
      if (got.count !== want.count) report_mismatch("count", got.count, want.count);
      if (got.min_key !== want.min_key)
        report_mismatch("min_key", longint'(got.min_key), longint'(want.min_key));
      if (got.max_key !== want.max_key)
        report_mismatch("max_key", longint'(got.max_key), longint'(want.max_key));
    endtask
  endclass

endpackage

// ----- verif/sorted_table_insert_remove_find_top_test.sv -----
// Top-level test for the sorted table: directed and random find, insert and
// remove beats under several capacities, with random gaps and stalls.
// Depends on sts_pkg, sts_if, sts_table_check_pkg and the block itself.
module sorted_table_insert_remove_find_top_test;
  import sts_pkg::*;
  import sts_table_check_pkg::*;

  logic clk;
  logic rst;
  bit   send_quiet;
  bit   sink_quiet;

  TableScoreboard sb;

  sts_req_if #(.KEY_WIDTH(KEY_W)) req_ch ();
  sts_rsp_if #(.KEY_WIDTH(KEY_W)) rsp_ch ();
  sts_cfg_if                      cfg_ch ();

  sorted_table_insert_remove_find_top #(
    .DEPTH(TBL_DEPTH),
    .KEY_WIDTH(KEY_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic send_request(input logic [ACTION_W-1:0] act, input key_t k);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.key    <= k;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(act, k);
  endtask

  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_capacity(v);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      0: return key_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return key_t'(0);
          default: return key_t'(-1);
        endcase
      end
      default: return key_t'(int'($urandom_range(0, 20)) - 10);
    endcase
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action(int insert_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return ACT_INSERT;
    if (r < insert_pct + (100 - insert_pct) / 2) return ACT_REMOVE;
    if (r < 95) return ACT_FIND;
    return ACT_SPARE;
  endfunction

  initial begin
    table_result_t seen;
    int stall;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = sink_quiet ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      seen.status   = rsp_ch.status;
      seen.position = rsp_ch.position;
      seen.count    = rsp_ch.count;
      seen.min_key  = rsp_ch.min_key;
      seen.max_key  = rsp_ch.max_key;
      sb.check_result(seen);
    end
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0] cap_plan [7];
    int lean [7];
    cap_plan = '{5'd31, 5'd1, 5'd0, 5'd3, 5'd16, 5'd9, 5'd20};
    lean = '{70, 40, 40, 45, 40, 50, 35};
    sb = new();
    rst = 1'b1;
    send_quiet = 1'b0;
    sink_quiet = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_FIND;
    req_ch.key = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(ACT_FIND, key_t'(0));
    send_request(ACT_REMOVE, key_t'(5));
    send_request(ACT_SPARE, key_t'(7));
    send_request(ACT_INSERT, KEY_MAX);
    send_request(ACT_INSERT, KEY_MIN);
    send_request(ACT_INSERT, key_t'(0));
    send_request(ACT_INSERT, key_t'(-1));
    send_request(ACT_INSERT, key_t'(1));
    send_request(ACT_INSERT, key_t'(0));
    send_request(ACT_FIND, KEY_MIN);
    send_request(ACT_FIND, KEY_MAX);
    send_request(ACT_SPARE, key_t'(1));
    send_request(ACT_REMOVE, key_t'(0));
    send_request(ACT_REMOVE, key_t'(0));
    send_request(ACT_FIND, key_t'(0));
    settle();
    write_capacity(5'd2);
    send_request(ACT_INSERT, key_t'(9));
    send_request(ACT_INSERT, KEY_MIN);
    send_request(ACT_REMOVE, KEY_MAX);
    send_request(ACT_REMOVE, key_t'(-1));
    send_request(ACT_REMOVE, key_t'(1));
    send_request(ACT_INSERT, key_t'(3));
    send_request(ACT_INSERT, key_t'(4));
    settle();
    write_capacity(5'd0);
    send_request(ACT_INSERT, key_t'(4));
    send_request(ACT_REMOVE, KEY_MIN);
    send_request(ACT_REMOVE, key_t'(3));
    send_request(ACT_INSERT, key_t'(2));

    for (int p = 0; p < 7; p++) begin
      settle();
      write_capacity(cap_plan[p]);
      send_quiet = (p % 3 == 1);
      sink_quiet = (p % 3 == 1);
      repeat (55) send_request(pick_action(lean[p]), pick_key());
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sts_pkg.sv
rtl/sts_if.sv
rtl/sts_cell.sv
rtl/sorted_table_insert_remove_find_top.sv
verif/sts_table_check_pkg.sv
verif/sorted_table_insert_remove_find_top_test.sv
